[rtl/cpm_pkg.sv]
// Package for the channel power monitor.
// Holds sizes, register indexes, the per-channel state record and its reset value.
// Used by channel_power_monitor and cpm_checker under rtl, and by the testbench.
package cpm_pkg;

  localparam int CHANNELS   = 128;
  localparam int ADDR_W     = $clog2(CHANNELS);
  localparam int CH_W       = 7;
  localparam int PWR_W      = 16;
  localparam int TIME_W     = 32;

  localparam int IN_W       = 80;
  localparam int OUT_W      = 88;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [PWR_W-1:0] NO_POWER      = 16'sh8000;
  localparam logic signed [PWR_W-1:0] PWR_MAX       = 16'sh7FFF;
  localparam logic signed [PWR_W-1:0] PWR_MIN       = 16'sh8001;
  localparam logic signed [PWR_W:0]   CLEAR_MARGIN  = 17'sd100;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_SPIKE_THR    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SPIKE_PERIOD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPIKE_EN     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LOSS_THR     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SNR      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_AMP_GAIN     = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PREAMP_EN    = 3'd6;

  // Everything the monitor keeps for one channel.
  typedef struct packed {
    logic signed [PWR_W-1:0] last_power;
    logic signed [PWR_W-1:0] last_snr;
    logic [TIME_W-1:0]       last_time;
    logic                    valid;
    logic                    loss;
    logic                    defect_valid;
    logic signed [PWR_W-1:0] lowest;
    logic signed [PWR_W-1:0] highest;
    logic                    snr_ok;
    logic signed [PWR_W-1:0] preamp;
    logic                    seen;
  } cpm_state_t;

  localparam int STATE_W = $bits(cpm_state_t);

  localparam cpm_state_t STATE_RESET = '{
    last_power:   NO_POWER,
    last_snr:     NO_POWER,
    last_time:    '0,
    valid:        1'b0,
    loss:         1'b0,
    defect_valid: 1'b0,
    lowest:       NO_POWER,
    highest:      NO_POWER,
    snr_ok:       1'b0,
    preamp:       NO_POWER,
    seen:         1'b0
  };

endpackage

[rtl/channel_power_monitor.sv]
// Channel power monitor: one word is taken every cycle while the output side keeps up.
// The channel record of an accepted word is read from the state RAM; the update stage then
// updates the record, writes it back and loads the output register. A write-back register
// forwards the last record so that words of one channel may follow each other directly.
// Reset (rst_n low, synchronous) restores the register defaults and marks all channel
// records unwritten, which then read as their reset value; no clearing pass is needed.
// Uses cpm_pkg and cpm_ram.
module channel_power_monitor (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // channel[6:0], power[22:7], snr[38:23], snr_valid[39], sample_seconds[71:40],
  // opm_fault[72], region_valid[73], monitor_enable[74], zero fill[79:75]
  input  logic [cpm_pkg::IN_W-1:0]        in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // accepted_power[15:0], accepted_snr[31:16], status_valid[32], preamp_power[48:33],
  // loss_of_power[49], spike_rejected[50], status_changed[51], defects_changed[52],
  // min_power[68:53], max_power[84:69], zero fill[87:85]
  output logic [cpm_pkg::OUT_W-1:0]       out_tdata,
  input  logic                            cfg_we,
  input  logic [cpm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [cpm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers.
  logic [14:0]                     spike_thr_r;
  logic [15:0]                     spike_period_r;
  logic                            spike_en_r;
  logic signed [cpm_pkg::PWR_W-1:0] loss_thr_r;
  logic signed [cpm_pkg::PWR_W-1:0] min_snr_r;
  logic signed [cpm_pkg::PWR_W-1:0] amp_gain_r;
  logic                            preamp_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spike_thr_r    <= 15'd300;
      spike_period_r <= 16'd10;
      spike_en_r     <= 1'b0;
      loss_thr_r     <= -16'sd3000;
      min_snr_r      <= '0;
      amp_gain_r     <= '0;
      preamp_en_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        cpm_pkg::REG_SPIKE_THR:    spike_thr_r    <= cfg_wdata[14:0];
        cpm_pkg::REG_SPIKE_PERIOD: spike_period_r <= cfg_wdata;
        cpm_pkg::REG_SPIKE_EN:     spike_en_r     <= cfg_wdata[0];
        cpm_pkg::REG_LOSS_THR:     loss_thr_r     <= cfg_wdata;
        cpm_pkg::REG_MIN_SNR:      min_snr_r      <= cfg_wdata;
        cpm_pkg::REG_AMP_GAIN:     amp_gain_r     <= cfg_wdata;
        cpm_pkg::REG_PREAMP_EN:    preamp_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input handshake and the update stage.
  logic                        s1_valid_r;
  logic [cpm_pkg::IN_W-1:0]    s1_data_r;
  logic                        s1_advance;
  logic                        in_fire;
  logic                        in_in_range;
  logic [cpm_pkg::ADDR_W-1:0]  in_addr;

  assign s1_advance = s1_valid_r && (!out_tvalid || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_fire    = in_tvalid && in_tready;
  assign in_addr    = in_tdata[cpm_pkg::ADDR_W-1:0];
  // A channel number beyond the table is dropped without a result.
  assign in_in_range = {1'b0, in_tdata[cpm_pkg::CH_W-1:0]} < (cpm_pkg::CH_W+1)'(cpm_pkg::CHANNELS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= in_in_range;
    end else if (s1_advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
    end
  end

  // Unpacked fields of the word in the update stage.
  logic [cpm_pkg::ADDR_W-1:0]       s1_addr;
  logic signed [cpm_pkg::PWR_W-1:0] s1_power;
  logic signed [cpm_pkg::PWR_W-1:0] s1_snr;
  logic                             s1_snr_valid;
  logic [cpm_pkg::TIME_W-1:0]       s1_time;
  logic                             s1_fault;
  logic                             s1_region;
  logic                             s1_enable;

  assign s1_addr      = s1_data_r[cpm_pkg::ADDR_W-1:0];
  assign s1_power     = s1_data_r[22:7];
  assign s1_snr       = s1_data_r[38:23];
  assign s1_snr_valid = s1_data_r[39];
  assign s1_time      = s1_data_r[71:40];
  assign s1_fault     = s1_data_r[72];
  assign s1_region    = s1_data_r[73];
  assign s1_enable    = s1_data_r[74];

  // State RAM, per-entry written flags and the write-back forwarding register.
  logic [cpm_pkg::STATE_W-1:0]       ram_rdata;
  logic [cpm_pkg::CHANNELS-1:0]      written_r;
  logic                              fwd_valid_r;
  logic [cpm_pkg::ADDR_W-1:0]        fwd_addr_r;
  cpm_pkg::cpm_state_t               fwd_state_r;
  cpm_pkg::cpm_state_t               cur;
  cpm_pkg::cpm_state_t               nxt;

  cpm_ram #(
    .WIDTH (cpm_pkg::STATE_W),
    .DEPTH (cpm_pkg::CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (s1_advance),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // The RAM read may have coincided with the write of the previous word.
  always_comb begin
    if (fwd_valid_r && fwd_addr_r == s1_addr) begin
      cur = fwd_state_r;
    end else if (written_r[s1_addr]) begin
      cur = cpm_pkg::cpm_state_t'(ram_rdata);
    end else begin
      cur = cpm_pkg::STATE_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r   <= '0;
      fwd_valid_r <= 1'b0;
    end else if (s1_advance) begin
      written_r[s1_addr] <= 1'b1;
      fwd_valid_r        <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      fwd_addr_r  <= s1_addr;
      fwd_state_r <= nxt;
    end
  end

  // Record update.
  logic signed [cpm_pkg::PWR_W:0]   jump_diff;
  logic [cpm_pkg::PWR_W:0]          jump_abs;
  logic [cpm_pkg::TIME_W-1:0]       dt;
  logic                             rej;
  logic                             sc;
  logic                             dc;

  assign jump_diff = {s1_power[15], s1_power} - {cur.last_power[15], cur.last_power};
  assign jump_abs  = jump_diff[cpm_pkg::PWR_W] ? 17'(-jump_diff) : 17'(jump_diff);
  assign dt        = s1_time - cur.last_time;

  always_comb begin
    logic signed [cpm_pkg::PWR_W:0]   pa_diff;
    logic signed [cpm_pkg::PWR_W-1:0] pa;
    logic signed [cpm_pkg::PWR_W:0]   clr_thr;
    logic signed [cpm_pkg::PWR_W:0]   lp17;
    logic                             loss;

    nxt     = cur;
    rej     = 1'b0;
    sc      = 1'b0;
    dc      = 1'b0;
    pa_diff = '0;
    pa      = cpm_pkg::NO_POWER;
    clr_thr = {loss_thr_r[15], loss_thr_r} + cpm_pkg::CLEAR_MARGIN;
    lp17    = '0;
    loss    = cur.loss;

    if (!s1_enable) begin
      nxt.valid      = 1'b0;
      nxt.last_power = cpm_pkg::NO_POWER;
      nxt.last_snr   = cpm_pkg::NO_POWER;
      nxt.snr_ok     = 1'b0;
      nxt.last_time  = '0;
      nxt.preamp     = cpm_pkg::NO_POWER;
    end else begin
      if (s1_region && !s1_fault) begin
        // With spike filtering on, a large jump that comes too soon after the last stored sample is ignored.
        rej = spike_en_r && (jump_abs > {2'b00, spike_thr_r}) &&
              (dt < {16'd0, spike_period_r});
        if (!rej) begin
          sc = (s1_power != cur.last_power) || (s1_snr != cur.last_snr) ||
               (s1_snr_valid != cur.snr_ok) || !cur.valid;
          nxt.last_power = s1_power;
          nxt.last_snr   = s1_snr;
          nxt.snr_ok     = s1_snr_valid;
          nxt.last_time  = s1_time;
          nxt.valid      = 1'b1;
          if (!cur.seen) begin
            nxt.lowest  = s1_power;
            nxt.highest = s1_power;
            nxt.seen    = 1'b1;
          end else begin
            if (s1_power < cur.lowest) begin
              nxt.lowest = s1_power;
            end
            if (s1_power > cur.highest) begin
              nxt.highest = s1_power;
            end
          end
        end
      end else if (cur.valid) begin
        nxt.valid = 1'b0;
        sc        = 1'b1;
      end

      if (preamp_en_r && nxt.valid) begin
        pa_diff = {nxt.last_power[15], nxt.last_power} - {amp_gain_r[15], amp_gain_r};
        if (nxt.last_power == cpm_pkg::NO_POWER) begin
          pa = cpm_pkg::NO_POWER;
        end else if (pa_diff > $signed({cpm_pkg::PWR_MAX[15], cpm_pkg::PWR_MAX})) begin
          pa = cpm_pkg::PWR_MAX;
        end else if (pa_diff < $signed({cpm_pkg::PWR_MIN[15], cpm_pkg::PWR_MIN})) begin
          pa = cpm_pkg::PWR_MIN;
        end else begin
          pa = pa_diff[cpm_pkg::PWR_W-1:0];
        end
        if (pa != cur.preamp) begin
          nxt.preamp = pa;
          sc         = 1'b1;
        end
      end

      // Hysteresis: clearing needs the power a margin above the set threshold.
      lp17 = {nxt.last_power[15], nxt.last_power};
      if (cur.loss) begin
        if (lp17 > clr_thr && nxt.last_snr > min_snr_r) begin
          loss = 1'b0;
        end
      end else if (nxt.last_power < loss_thr_r || nxt.last_snr < min_snr_r) begin
        loss = 1'b1;
      end
      nxt.loss         = loss;
      nxt.defect_valid = 1'b1;
      dc = (loss != cur.loss) || !cur.defect_valid;
    end
  end

  // Output register.
  logic                      out_valid_r;
  logic [cpm_pkg::OUT_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data_r <= {3'b000, nxt.highest, nxt.lowest, dc, sc, rej, nxt.loss,
                     nxt.preamp, nxt.valid, nxt.last_snr, nxt.last_power};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[rtl/cpm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/cpm_checker.sv]
// Port-level checks for the channel power monitor, bound to the top level.
// Uses cpm_pkg for port widths.
module cpm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cpm_pkg::OUT_W-1:0]       out_tdata
);

  // No result word may appear straight out of reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // A stalled result word stays and keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  // The running minimum never exceeds the running maximum.
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $signed(out_tdata[68:53]) <= $signed(out_tdata[84:69]))
    else $error("minimum power above maximum power");

  // The input side only stalls while a result word waits for the receiver.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while the output side was free");

endmodule

bind channel_power_monitor cpm_checker u_cpm_checker (.*);

[verif/tb_channel_power_monitor.sv]
`timescale 1ns / 1ps
// Self-checking testbench for channel_power_monitor: drives sample words, predicts the
// per-channel status and defect words and compares every result word field by field.
// Depends on rtl/cpm_pkg.sv and the channel_power_monitor RTL.
module tb_channel_power_monitor;
  import cpm_pkg::*;

  localparam int NOPWR       = NO_POWER;
  localparam int PMAX        = PWR_MAX;
  localparam int PMIN        = PWR_MIN;
  localparam int MARGIN      = CLEAR_MARGIN;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;

  // One sample word, first field in the lowest bits.
  typedef struct packed {
    logic [4:0]              pad;
    logic                    monitor_enable;
    logic                    region_valid;
    logic                    opm_fault;
    logic [TIME_W-1:0]       sample_seconds;
    logic                    snr_valid;
    logic signed [PWR_W-1:0] snr;
    logic signed [PWR_W-1:0] power;
    logic [CH_W-1:0]         channel;
  } sample_t;

  // One status word, first field in the lowest bits.
  typedef struct packed {
    logic [2:0]              pad;
    logic signed [PWR_W-1:0] max_power;
    logic signed [PWR_W-1:0] min_power;
    logic                    defects_changed;
    logic                    status_changed;
    logic                    spike_rejected;
    logic                    loss_of_power;
    logic signed [PWR_W-1:0] preamp_power;
    logic                    status_valid;
    logic signed [PWR_W-1:0] accepted_snr;
    logic signed [PWR_W-1:0] accepted_power;
  } monitor_result_t;

  typedef struct packed {
    int thr;
    int period;
    bit filter;
    int loss;
    int snr_min;
    int gain;
    bit preamp;
  } monitor_setting_t;

  class power_scoreboard;
    int          spike_thr;
    logic [15:0] spike_window;
    bit          spike_on;
    int          loss_thr;
    int          snr_floor;
    int          gain;
    bit          preamp_on;

    int          stored_power [CHANNELS];
    int          stored_snr   [CHANNELS];
    logic [31:0] stored_time  [CHANNELS];
    bit          status_ok    [CHANNELS];
    bit          loss_on      [CHANNELS];
    bit          defect_ok    [CHANNELS];
    int          lowest       [CHANNELS];
    int          highest      [CHANNELS];
    bit          snr_flag     [CHANNELS];
    int          preamp_val   [CHANNELS];
    bit          have_range   [CHANNELS];

    monitor_result_t status_q[$];
    int errors;

    function new();
      int i;
      spike_thr    = 300;
      spike_window = 16'd10;
      spike_on     = 1'b0;
      loss_thr     = -3000;
      snr_floor    = 0;
      gain         = 0;
      preamp_on    = 1'b0;
      errors       = 0;
      for (i = 0; i < CHANNELS; i++) begin
        stored_power[i] = NOPWR;
        stored_snr[i]   = NOPWR;
        stored_time[i]  = '0;
        status_ok[i]    = 1'b0;
        loss_on[i]      = 1'b0;
        defect_ok[i]    = 1'b0;
        lowest[i]       = NOPWR;
        highest[i]      = NOPWR;
        snr_flag[i]     = 1'b0;
        preamp_val[i]   = NOPWR;
        have_range[i]   = 1'b0;
      end
    endfunction

    function void set_register(logic [CFG_ADDR_W-1:0] idx, logic [15:0] v);
      case (idx)
        REG_SPIKE_THR:    spike_thr = int'(v[14:0]);
        REG_SPIKE_PERIOD: spike_window = v;
        REG_SPIKE_EN:     spike_on = v[0];
        REG_LOSS_THR:     loss_thr = int'($signed(v));
        REG_MIN_SNR:      snr_floor = int'($signed(v));
        REG_AMP_GAIN:     gain = int'($signed(v));
        REG_PREAMP_EN:    preamp_on = v[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    // Works out the status word that an accepted sample word produces.
    function void note_sample(sample_t smp);
      int c, p, s, d, pa;
      logic [31:0] dt;
      bit sc, dc, rej, loss;
      monitor_result_t r;
      c = smp.channel;
      p = smp.power;
      s = smp.snr;
      sc = 1'b0;
      dc = 1'b0;
      rej = 1'b0;
      if (!smp.monitor_enable) begin
        status_ok[c]    = 1'b0;
        stored_power[c] = NOPWR;
        stored_snr[c]   = NOPWR;
        snr_flag[c]     = 1'b0;
        stored_time[c]  = '0;
        preamp_val[c]   = NOPWR;
      end else begin
        if (smp.region_valid && !smp.opm_fault) begin
          d = p - stored_power[c];
          if (d < 0) d = -d;
          dt = smp.sample_seconds - stored_time[c];
          if (spike_on && d > spike_thr && dt < {16'b0, spike_window}) begin
            rej = 1'b1;
          end else begin
            if (p != stored_power[c] || s != stored_snr[c] || smp.snr_valid != snr_flag[c])
              sc = 1'b1;
            stored_power[c] = p;
            stored_snr[c]   = s;
            snr_flag[c]     = smp.snr_valid;
            stored_time[c]  = smp.sample_seconds;
            if (!status_ok[c]) begin
              status_ok[c] = 1'b1;
              sc = 1'b1;
            end
            if (!have_range[c]) begin
              lowest[c]     = p;
              highest[c]    = p;
              have_range[c] = 1'b1;
            end else begin
              if (p < lowest[c]) lowest[c] = p;
              if (p > highest[c]) highest[c] = p;
            end
          end
        end else if (status_ok[c]) begin
          status_ok[c] = 1'b0;
          sc = 1'b1;
        end

        if (preamp_on && status_ok[c]) begin
          pa = NOPWR;
          if (stored_power[c] != NOPWR) begin
            pa = stored_power[c] - gain;
            if (pa > PMAX) pa = PMAX;
            else if (pa < PMIN) pa = PMIN;
          end
          if (pa != preamp_val[c]) begin
            preamp_val[c] = pa;
            sc = 1'b1;
          end
        end

        // Hysteresis: set below either limit, clear only above the raised power limit.
        loss = loss_on[c];
        if (loss) begin
          if (stored_power[c] > loss_thr + MARGIN && stored_snr[c] > snr_floor) loss = 1'b0;
        end else if (stored_power[c] < loss_thr || stored_snr[c] < snr_floor) begin
          loss = 1'b1;
        end
        if (loss != loss_on[c]) begin
          loss_on[c] = loss;
          dc = 1'b1;
        end
        if (!defect_ok[c]) begin
          defect_ok[c] = 1'b1;
          dc = 1'b1;
        end
      end

      r = '0;
      r.accepted_power  = 16'(stored_power[c]);
      r.accepted_snr    = 16'(stored_snr[c]);
      r.status_valid    = status_ok[c];
      r.preamp_power    = 16'(preamp_val[c]);
      r.loss_of_power   = loss_on[c];
      r.spike_rejected  = rej;
      r.status_changed  = sc;
      r.defects_changed = dc;
      r.min_power       = 16'(have_range[c] ? lowest[c] : NOPWR);
      r.max_power       = 16'(have_range[c] ? highest[c] : NOPWR);
      status_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %h got %h", $time, name, want, got);
      end
    endfunction

    function void check_word(monitor_result_t got);
      monitor_result_t want;
      if (status_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: status word %h arrived with nothing expected", $time, got);
        return;
      end
      want = status_q.pop_front();
      compare_field("accepted_power", want.accepted_power, got.accepted_power);
      compare_field("accepted_snr", want.accepted_snr, got.accepted_snr);
      compare_field("status_valid", 16'(want.status_valid), 16'(got.status_valid));
      compare_field("preamp_power", want.preamp_power, got.preamp_power);
      compare_field("loss_of_power", 16'(want.loss_of_power), 16'(got.loss_of_power));
      compare_field("spike_rejected", 16'(want.spike_rejected), 16'(got.spike_rejected));
      compare_field("status_changed", 16'(want.status_changed), 16'(got.status_changed));
      compare_field("defects_changed", 16'(want.defects_changed), 16'(got.defects_changed));
      compare_field("min_power", want.min_power, got.min_power);
      compare_field("max_power", want.max_power, got.max_power);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  power_scoreboard sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_done = 0;
  int stall_cycles = 0;
  logic [31:0] chan_time [CHANNELS];
  int          chan_pwr  [CHANNELS];

  channel_power_monitor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int clamp16(int v);
    if (v > PMAX) return PMAX;
    if (v < NOPWR) return NOPWR;
    return v;
  endfunction

  function automatic sample_t make_sample(int ch, int p, int s, bit sv, logic [31:0] t,
                                          bit fault, bit region, bit en);
    sample_t r;
    r = '0;
    r.channel        = ch[CH_W-1:0];
    r.power          = p[15:0];
    r.snr            = s[15:0];
    r.snr_valid      = sv;
    r.sample_seconds = t;
    r.opm_fault      = fault;
    r.region_valid   = region;
    r.monitor_enable = en;
    return r;
  endfunction

  task automatic send_sample(sample_t smp);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= smp;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(smp);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[15:0];
    @(posedge clk);
    sb.set_register(idx, value[15:0]);
  endtask

  task automatic apply_setting(monitor_setting_t st);
    cfg_write(REG_SPIKE_THR, st.thr);
    cfg_write(REG_SPIKE_PERIOD, st.period);
    cfg_write(REG_SPIKE_EN, int'(st.filter));
    cfg_write(REG_LOSS_THR, st.loss);
    cfg_write(REG_MIN_SNR, st.snr_min);
    cfg_write(REG_AMP_GAIN, st.gain);
    cfg_write(REG_PREAMP_EN, int'(st.preamp));
    cfg_we <= 1'b0;
  endtask

  // Random words mostly revisit a few channels with plausible time steps and power
  // moves, so that spike windows and hysteresis get exercised; the rest is noise.
  task automatic run_phase(int n, monitor_setting_t st, int snd, int rcv,
                           bit do_hold, bit do_pause);
    int k, j, r, ch, p, s, delta;
    int pool [8];
    logic [31:0] t;
    send_idle_pct = snd;
    recv_idle_pct <= rcv;
    apply_setting(st);
    for (j = 0; j < 8; j++) pool[j] = $urandom_range(CHANNELS - 1);
    for (k = 0; k < n; k++) begin
      if (do_hold && k == n / 3) hold_req <= hold_req + 1;
      if (do_pause && k == n / 2) wait_drained();

      ch = ($urandom_range(99) < 75) ? pool[$urandom_range(7)] : $urandom_range(CHANNELS - 1);

      r = $urandom_range(99);
      if (r < 45) delta = $urandom_range(st.period > 0 ? st.period - 1 : 0);
      else if (r < 70) delta = st.period - 1 + int'($urandom_range(2));
      else if (r < 92) delta = $urandom_range(100000);
      else delta = $urandom;
      t = chan_time[ch] + delta;
      chan_time[ch] = t;

      r = $urandom_range(99);
      if (r < 40) p = chan_pwr[ch] + int'($urandom_range(2 * st.thr + 2)) - (st.thr + 1);
      else if (r < 60) p = st.loss + int'($urandom_range(400)) - 200;
      else if (r < 75) p = st.loss + MARGIN + int'($urandom_range(100)) - 50;
      else if (r < 80) p = r[0] ? PMAX : NOPWR;
      else p = int'($urandom_range(65535)) - 32768;
      p = clamp16(p);
      chan_pwr[ch] = p;

      if ($urandom_range(99) < 50) s = clamp16(st.snr_min + int'($urandom_range(600)) - 300);
      else s = int'($urandom_range(65535)) - 32768;

      send_sample(make_sample(ch, p, s, $urandom_range(1), t, $urandom_range(99) < 8,
                              $urandom_range(99) < 92, $urandom_range(99) < 94));
    end
    wait_drained();
  endtask

  // Output side: random back-pressure, plus a long hold-off on request.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = hold_done + 1;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    monitor_setting_t st;
    int i;
    sb = new();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    for (i = 0; i < CHANNELS; i++) begin
      chan_time[i] = i[0] ? $urandom : 32'd0;
      chan_pwr[i]  = -1000;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    st = '{thr: 300, period: 10, filter: 1'b1, loss: -3000, snr_min: 0, gain: 1000,
           preamp: 1'b1};
    apply_setting(st);
    send_sample(make_sample(0, -1000, 2000, 1, 100, 0, 1, 1));
    send_sample(make_sample(0, -1000, 2000, 1, 101, 0, 1, 1));
    // A 1000 mBm jump four seconds later is a spike; at ten seconds it is taken.
    send_sample(make_sample(0, 0, 2000, 1, 105, 0, 1, 1));
    send_sample(make_sample(0, 0, 2000, 0, 111, 0, 1, 1));
    // Loss sets below the limit, holds inside the margin, clears above it.
    send_sample(make_sample(0, -3001, 2000, 1, 200, 0, 1, 1));
    send_sample(make_sample(0, -2950, 2000, 1, 300, 0, 1, 1));
    send_sample(make_sample(0, -2899, 2000, 1, 400, 0, 1, 1));
    send_sample(make_sample(0, -2899, -1, 1, 500, 0, 1, 1));
    send_sample(make_sample(0, -2899, -1, 1, 600, 0, 0, 1));
    send_sample(make_sample(0, -2899, 5, 1, 700, 1, 1, 1));
    send_sample(make_sample(0, 1234, 5, 1, 800, 0, 1, 0));
    // An earlier time stamp wraps to a long gap, so the jump is accepted.
    send_sample(make_sample(1, 1000, 100, 1, 1000, 0, 1, 1));
    send_sample(make_sample(1, 9000, 100, 1, 999, 0, 1, 1));
    send_sample(make_sample(127, PMAX, PMAX, 1, 32'hFFFF_FFFF, 0, 1, 1));
    send_sample(make_sample(127, NOPWR, NOPWR, 0, 32'h0000_0000, 0, 1, 1));
    send_sample(make_sample(126, NOPWR, NOPWR, 1, 20, 0, 1, 1));
    send_sample(make_sample(85, PMIN, 0, 1, 32'h5555_5555, 0, 1, 1));
    send_sample(make_sample(42, PMAX, 1, 1, 32'hAAAA_AAAA, 0, 1, 1));
    send_sample(make_sample(42, -5000, 1, 1, 32'hAAAA_AAAA, 0, 1, 1));
    send_sample(make_sample(85, PMIN, 0, 0, 32'h5555_5555, 1, 0, 0));
    wait_drained();

    st = '{thr: 400, period: 30, filter: 1'b1, loss: -3000, snr_min: 1000, gain: 1500,
           preamp: 1'b1};
    run_phase(292, st, 31, 53, 1'b0, 1'b0);
    st = '{thr: 0, period: 65535, filter: 1'b1, loss: -32768, snr_min: -32768,
           gain: -32768, preamp: 1'b1};
    run_phase(292, st, 31, 53, 1'b0, 1'b0);
    st = '{thr: 32767, period: 0, filter: 1'b1, loss: 32767, snr_min: 32767, gain: 32767,
           preamp: 1'b1};
    run_phase(292, st, 53, 31, 1'b0, 1'b1);
    st = '{thr: 500, period: 100, filter: 1'b0, loss: -2000, snr_min: 1500, gain: 2000,
           preamp: 1'b0};
    run_phase(292, st, 53, 31, 1'b0, 1'b0);
    st = '{thr: 150, period: 5, filter: 1'b1, loss: -1500, snr_min: -200, gain: -700,
           preamp: 1'b1};
    run_phase(292, st, 0, 0, 1'b1, 1'b0);
    st = '{thr: 300, period: 10, filter: 1'b0, loss: -3000, snr_min: 0, gain: 0,
           preamp: 1'b0};
    run_phase(292, st, 0, 0, 1'b0, 1'b0);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
